@@ rtl/core/ssmm_pkg.sv @@
// Shared types and constants for the soft-switch memory manager.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package ssmm_pkg;

  // Item modes
  localparam logic [2:0] MODE_READ  = 3'd0;
  localparam logic [2:0] MODE_WRITE = 3'd1;
  localparam logic [2:0] MODE_RESET = 3'd2;
  localparam logic [2:0] MODE_HIRES = 3'd3;
  localparam logic [2:0] MODE_PAGE2 = 3'd4;

  // Address decode constants
  localparam logic [15:0] LC_MASK     = 16'hFFF0;
  localparam logic [15:0] LC_BASE     = 16'hC080;
  localparam logic [15:0] SW_BASE     = 16'hC000;
  localparam logic [11:0] STAT_PAGE   = 12'hC01;
  localparam logic [7:0]  C3_PAGE     = 8'hC3;
  localparam logic [3:0]  CX_NIBBLE   = 4'hC;
  localparam logic [15:0] C8_OFF_ADDR = 16'hCFFF;
  localparam logic [6:0]  KBD_MASK    = 7'h7F;

  // Status register select (low address nibble of C011-C01F)
  localparam logic [3:0] ST_BANK2   = 4'h1;
  localparam logic [3:0] ST_HRAMRD  = 4'h2;
  localparam logic [3:0] ST_AUXRD   = 4'h3;
  localparam logic [3:0] ST_AUXWR   = 4'h4;
  localparam logic [3:0] ST_CXROM   = 4'h5;
  localparam logic [3:0] ST_ALTZP   = 4'h6;
  localparam logic [3:0] ST_SLOTC3  = 4'h7;
  localparam logic [3:0] ST_80STORE = 4'h8;
  localparam logic [3:0] ST_VBL     = 4'h9;
  localparam logic [3:0] ST_TEXT    = 4'hA;
  localparam logic [3:0] ST_MIXED   = 4'hB;
  localparam logic [3:0] ST_PAGE2   = 4'hC;
  localparam logic [3:0] ST_HIRES   = 4'hD;
  localparam logic [3:0] ST_ALTCHAR = 4'hE;

  // Soft switch select (address bits 3:1 of C000-C00F writes)
  localparam logic [2:0] SW_80STORE = 3'd0;
  localparam logic [2:0] SW_AUXRD   = 3'd1;
  localparam logic [2:0] SW_AUXWR   = 3'd2;
  localparam logic [2:0] SW_CXROM   = 3'd3;
  localparam logic [2:0] SW_ALTZP   = 3'd4;
  localparam logic [2:0] SW_SLOTC3  = 3'd5;

  typedef struct packed {
    logic [2:0]  mode;
    logic [15:0] address;
    logic        flag_value;
    logic [7:0]  keyboard_data;
    logic [7:0]  rom_data;
    logic [7:0]  floating_data;
    logic        video_text;
    logic        video_mixed;
    logic        video_altchar;
    logic        video_col80;
    logic        video_vbl;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       hram_read_on;
    logic       hram_write_on;
    logic       bank_one;
    logic       aux_zero_page;
    logic [4:0] aux_read_map;
    logic [4:0] aux_write_map;
    logic [3:0] cxxx_read_map;
    logic [3:0] cxxx_write_map;
    logic       store80_on;
    logic       slot_cfff_read;
  } result_t;

  typedef struct packed {
    logic bank_one;
    logic hram_read;
    logic pre_write;
    logic hram_write;
    logic aux_read;
    logic aux_write;
    logic store80;
    logic cx_rom;
    logic alt_zp;
    logic slot_c3;
    logic c8_rom;
    logic hires;
    logic page2;
  } flags_t;

  // Aux region map: 04-07 follows page2 under 80STORE, 20-3F also needs hires
  function automatic logic [4:0] region_map(input logic base, input flags_t f);
    logic r47;
    logic r2f;
    r47 = f.store80 ? f.page2 : base;
    r2f = (f.store80 && f.hires) ? f.page2 : base;
    return {base, r2f, base, r47, base};
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/ssmm_if.sv @@
// Valid/ready channel interfaces for the soft-switch memory manager.
// Depends on nothing; field names follow the item and result layouts.
`default_nettype none

interface ssmm_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [15:0] address;
  logic        flag_value;
  logic [7:0]  keyboard_data;
  logic [7:0]  rom_data;
  logic [7:0]  floating_data;
  logic        video_text;
  logic        video_mixed;
  logic        video_altchar;
  logic        video_col80;
  logic        video_vbl;

  modport source (
    output valid, mode, address, flag_value, keyboard_data, rom_data, floating_data,
           video_text, video_mixed, video_altchar, video_col80, video_vbl,
    input  ready
  );
  modport sink (
    input  valid, mode, address, flag_value, keyboard_data, rom_data, floating_data,
           video_text, video_mixed, video_altchar, video_col80, video_vbl,
    output ready
  );
endinterface

interface ssmm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       hram_read_on;
  logic       hram_write_on;
  logic       bank_one;
  logic       aux_zero_page;
  logic [4:0] aux_read_map;
  logic [4:0] aux_write_map;
  logic [3:0] cxxx_read_map;
  logic [3:0] cxxx_write_map;
  logic       store80_on;
  logic       slot_cfff_read;

  modport source (
    output valid, read_data, hram_read_on, hram_write_on, bank_one, aux_zero_page,
           aux_read_map, aux_write_map, cxxx_read_map, cxxx_write_map, store80_on,
           slot_cfff_read,
    input  ready
  );
  modport sink (
    input  valid, read_data, hram_read_on, hram_write_on, bank_one, aux_zero_page,
           aux_read_map, aux_write_map, cxxx_read_map, cxxx_write_map, store80_on,
           slot_cfff_read,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/core/softswitch_memory_manager.sv @@
// Soft-switch memory manager with language-card banking.
// An accepted beat passes through the input register and then the result register.
// Throughput: one beat per cycle unless a held result stalls it; the decode and switch update sit in
// one register-to-register stage, and each beat sees the switch state left by the beat before it.
// Reset: rst_ni clears all switches, hires and page2 copies, and both valid flags.
// Depends on ssmm_pkg and the ssmm_in_if / ssmm_out_if interfaces.
`default_nettype none

module softswitch_memory_manager (
  input  wire        clk_i,
  input  wire        rst_ni,
  ssmm_in_if.sink    in_i,
  ssmm_out_if.source out_o
);

  ssmm_pkg::item_t   item_q;
  logic              item_valid_q;
  ssmm_pkg::result_t res_q;
  ssmm_pkg::result_t res_d;
  logic              res_valid_q;
  ssmm_pkg::flags_t  flag_q;
  ssmm_pkg::flags_t  flag_d;
  logic              advance;
  logic              in_ready;

  assign advance  = !res_valid_q || out_o.ready;
  assign in_ready = !item_valid_q || advance;
  assign in_i.ready = in_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      item_q.mode          <= in_i.mode;
      item_q.address       <= in_i.address;
      item_q.flag_value    <= in_i.flag_value;
      item_q.keyboard_data <= in_i.keyboard_data;
      item_q.rom_data      <= in_i.rom_data;
      item_q.floating_data <= in_i.floating_data;
      item_q.video_text    <= in_i.video_text;
      item_q.video_mixed   <= in_i.video_mixed;
      item_q.video_altchar <= in_i.video_altchar;
      item_q.video_col80   <= in_i.video_col80;
      item_q.video_vbl     <= in_i.video_vbl;
    end
  end

  // Switch update and result decode
  always_comb begin
    logic [15:0] a;
    logic        lc_hit;
    logic        stat_hit;
    logic        cx_hit;
    logic        c3_hit;
    logic        stat_bit;
    logic        cx;
    logic        c3;
    logic        c8;

    a        = item_q.address;
    flag_d   = flag_q;
    res_d    = '0;
    lc_hit   = (a & ssmm_pkg::LC_MASK) == ssmm_pkg::LC_BASE;
    stat_hit = (a[15:4] == ssmm_pkg::STAT_PAGE) && (a[3:0] != 4'h0);
    cx_hit   = (a[15:12] == ssmm_pkg::CX_NIBBLE) && (a[11:8] != 4'h0);
    c3_hit   = a[15:8] == ssmm_pkg::C3_PAGE;

    case (a[3:0])
      ssmm_pkg::ST_BANK2:   stat_bit = !flag_q.bank_one;
      ssmm_pkg::ST_HRAMRD:  stat_bit = flag_q.hram_read;
      ssmm_pkg::ST_AUXRD:   stat_bit = flag_q.aux_read;
      ssmm_pkg::ST_AUXWR:   stat_bit = flag_q.aux_write;
      ssmm_pkg::ST_CXROM:   stat_bit = flag_q.cx_rom;
      ssmm_pkg::ST_ALTZP:   stat_bit = flag_q.alt_zp;
      ssmm_pkg::ST_SLOTC3:  stat_bit = flag_q.slot_c3;
      ssmm_pkg::ST_80STORE: stat_bit = flag_q.store80;
      ssmm_pkg::ST_VBL:     stat_bit = !item_q.video_vbl;
      ssmm_pkg::ST_TEXT:    stat_bit = item_q.video_text;
      ssmm_pkg::ST_MIXED:   stat_bit = item_q.video_mixed;
      ssmm_pkg::ST_PAGE2:   stat_bit = flag_q.page2;
      ssmm_pkg::ST_HIRES:   stat_bit = flag_q.hires;
      ssmm_pkg::ST_ALTCHAR: stat_bit = item_q.video_altchar;
      default:              stat_bit = item_q.video_col80;
    endcase

    case (item_q.mode)
      ssmm_pkg::MODE_READ: begin
        if (lc_hit) begin
          if (!a[0]) begin
            flag_d.hram_write = 1'b0;
          end else if (flag_q.pre_write) begin
            flag_d.hram_write = 1'b1;
          end
          flag_d.pre_write = a[0];
          flag_d.hram_read = !(a[1] ^ a[0]);
          flag_d.bank_one  = a[3];
          res_d.read_data  = item_q.floating_data;
        end else if (stat_hit) begin
          res_d.read_data = {stat_bit, item_q.keyboard_data[6:0] & ssmm_pkg::KBD_MASK};
        end else if (cx_hit) begin
          if (c3_hit) begin
            if (!flag_q.slot_c3) begin
              flag_d.c8_rom = 1'b1;
            end
          end else if (a == ssmm_pkg::C8_OFF_ADDR && flag_q.c8_rom) begin
            // Disarm; forward to the slot bus when slot ROM is mapped
            flag_d.c8_rom        = 1'b0;
            res_d.slot_cfff_read = !flag_q.cx_rom;
          end
          res_d.read_data = item_q.rom_data;
        end else begin
          res_d.read_data = item_q.floating_data;
        end
      end
      ssmm_pkg::MODE_WRITE: begin
        if (lc_hit) begin
          if (!a[0]) begin
            flag_d.hram_write = 1'b0;
          end
          flag_d.pre_write = 1'b0;
          flag_d.hram_read = !(a[1] ^ a[0]);
          flag_d.bank_one  = a[3];
        end else if ((a & ssmm_pkg::LC_MASK) == ssmm_pkg::SW_BASE) begin
          case (a[3:1])
            ssmm_pkg::SW_80STORE: flag_d.store80   = a[0];
            ssmm_pkg::SW_AUXRD:   flag_d.aux_read  = a[0];
            ssmm_pkg::SW_AUXWR:   flag_d.aux_write = a[0];
            ssmm_pkg::SW_CXROM:   flag_d.cx_rom    = a[0];
            ssmm_pkg::SW_ALTZP:   flag_d.alt_zp    = a[0];
            ssmm_pkg::SW_SLOTC3:  flag_d.slot_c3   = a[0];
            default: ;
          endcase
        end else if (c3_hit) begin
          if (!flag_q.slot_c3) begin
            flag_d.c8_rom = 1'b1;
          end
        end else if (a == ssmm_pkg::C8_OFF_ADDR) begin
          flag_d.c8_rom = 1'b0;
        end
      end
      ssmm_pkg::MODE_RESET: begin
        // Clear switches; hires and page2 copies hold
        flag_d       = '0;
        flag_d.hires = flag_q.hires;
        flag_d.page2 = flag_q.page2;
      end
      ssmm_pkg::MODE_HIRES: flag_d.hires = item_q.flag_value;
      ssmm_pkg::MODE_PAGE2: flag_d.page2 = item_q.flag_value;
      default: ;
    endcase

    cx = flag_d.cx_rom;
    c3 = cx | !flag_d.slot_c3;
    c8 = cx | flag_d.c8_rom;

    res_d.hram_read_on   = flag_d.hram_read;
    res_d.hram_write_on  = flag_d.hram_write;
    res_d.bank_one       = flag_d.bank_one;
    res_d.aux_zero_page  = flag_d.alt_zp;
    res_d.aux_read_map   = ssmm_pkg::region_map(flag_d.aux_read, flag_d);
    res_d.aux_write_map  = ssmm_pkg::region_map(flag_d.aux_write, flag_d);
    res_d.cxxx_read_map  = {c8, cx, c3, cx};
    res_d.cxxx_write_map = {c8, 1'b0, c3, 1'b0};
    res_d.store80_on     = flag_d.store80;
  end

  // Switch state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flag_q      <= '0;
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= item_valid_q;
      if (item_valid_q) begin
        flag_q <= flag_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && item_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.read_data      = res_q.read_data;
  assign out_o.hram_read_on   = res_q.hram_read_on;
  assign out_o.hram_write_on  = res_q.hram_write_on;
  assign out_o.bank_one       = res_q.bank_one;
  assign out_o.aux_zero_page  = res_q.aux_zero_page;
  assign out_o.aux_read_map   = res_q.aux_read_map;
  assign out_o.aux_write_map  = res_q.aux_write_map;
  assign out_o.cxxx_read_map  = res_q.cxxx_read_map;
  assign out_o.cxxx_write_map = res_q.cxxx_write_map;
  assign out_o.store80_on     = res_q.store80_on;
  assign out_o.slot_cfff_read = res_q.slot_cfff_read;

`ifndef SYNTHESIS
  // Input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (res_valid_q && !out_o.ready && item_valid_q))
    else $error("input stalled without a held result");

  // A reset beat leaves bank_one, hram_write, store80, c8_rom and slot_c3 cleared
  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && item_valid_q && item_q.mode == ssmm_pkg::MODE_RESET) |=>
      (flag_q.bank_one == 1'b0 && flag_q.hram_write == 1'b0 && flag_q.store80 == 1'b0 &&
       flag_q.c8_rom == 1'b0 && flag_q.slot_c3 == 1'b0))
    else $error("reset beat left a switch set");

  // A forwarded CFFF read always leaves C800 mapped to the slot
  a_cfff_unmaps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.slot_cfff_read) |-> !res_q.cxxx_read_map[3])
    else $error("CFFF forward with internal C800 still mapped");

  // A held result keeps the switch state frozen
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flag_q))
    else $error("switch state moved during a stall");
`endif

endmodule

`default_nettype wire

@@ dv/softswitch_memory_manager_tb.sv @@
// Testbench for softswitch_memory_manager: directed soft-switch and bank sequences, then random
// bus traffic under sender and receiver idling. Depends on ssmm_pkg and ssmm_in_if/ssmm_out_if.
`timescale 1ns / 1ps

module softswitch_memory_manager_tb;

  localparam logic [2:0] MODE_LAST       = 3'd7;
  localparam logic [2:0] SW_SPARE        = 3'd6;
  localparam logic [3:0] ST_FLOAT        = 4'h0;
  localparam logic [3:0] ST_COL80        = 4'hF;
  localparam int         HOLD_OFF_CYCLES = 300;

  logic clk;
  logic rst_n;

  ssmm_in_if  in_if ();
  ssmm_out_if out_if ();

  softswitch_memory_manager u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  ssmm_pkg::flags_t  sw_state;
  ssmm_pkg::result_t expected_maps[$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      stall_left = 0;
  int      hold_off_req = 0;
  int      hold_off_seen = 0;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [4:0] aux_regions(input logic base);
    logic r47;
    logic r2f;
    r47 = sw_state.store80 ? sw_state.page2 : base;
    r2f = (sw_state.store80 && sw_state.hires) ? sw_state.page2 : base;
    return {base, r2f, base, r47, base};
  endfunction

  function automatic void select_bank(input logic [15:0] a);
    sw_state.hram_read = !(a[1] ^ a[0]);
    sw_state.bank_one  = a[3];
  endfunction

  function automatic ssmm_pkg::result_t predict_access(input ssmm_pkg::item_t it);
    ssmm_pkg::result_t r;
    logic [15:0] a;
    logic        st;
    logic        c3;
    logic        c8;
    logic        keep_hires;
    logic        keep_page2;
    a = it.address;
    r = '0;
    case (it.mode)
      ssmm_pkg::MODE_READ: begin
        if ((a & ssmm_pkg::LC_MASK) == ssmm_pkg::LC_BASE) begin
          if (!a[0]) sw_state.hram_write = 1'b0;
          else if (sw_state.pre_write) sw_state.hram_write = 1'b1;
          sw_state.pre_write = a[0];
          select_bank(a);
          r.read_data = it.floating_data;
        end else if (a[15:4] == ssmm_pkg::STAT_PAGE && a[3:0] != ST_FLOAT) begin
          case (a[3:0])
            ssmm_pkg::ST_BANK2:   st = !sw_state.bank_one;
            ssmm_pkg::ST_HRAMRD:  st = sw_state.hram_read;
            ssmm_pkg::ST_AUXRD:   st = sw_state.aux_read;
            ssmm_pkg::ST_AUXWR:   st = sw_state.aux_write;
            ssmm_pkg::ST_CXROM:   st = sw_state.cx_rom;
            ssmm_pkg::ST_ALTZP:   st = sw_state.alt_zp;
            ssmm_pkg::ST_SLOTC3:  st = sw_state.slot_c3;
            ssmm_pkg::ST_80STORE: st = sw_state.store80;
            ssmm_pkg::ST_VBL:     st = !it.video_vbl;
            ssmm_pkg::ST_TEXT:    st = it.video_text;
            ssmm_pkg::ST_MIXED:   st = it.video_mixed;
            ssmm_pkg::ST_PAGE2:   st = sw_state.page2;
            ssmm_pkg::ST_HIRES:   st = sw_state.hires;
            ssmm_pkg::ST_ALTCHAR: st = it.video_altchar;
            default:              st = it.video_col80;
          endcase
          r.read_data = {st, it.keyboard_data[6:0] & ssmm_pkg::KBD_MASK};
        end else if (a[15:12] == ssmm_pkg::CX_NIBBLE && a[11:8] != 4'h0) begin
          if (a[15:8] == ssmm_pkg::C3_PAGE) begin
            if (!sw_state.slot_c3) sw_state.c8_rom = 1'b1;
          end else if (a == ssmm_pkg::C8_OFF_ADDR && sw_state.c8_rom) begin
            sw_state.c8_rom  = 1'b0;
            r.slot_cfff_read = !sw_state.cx_rom;
          end
          r.read_data = it.rom_data;
        end else begin
          r.read_data = it.floating_data;
        end
      end
      ssmm_pkg::MODE_WRITE: begin
        if ((a & ssmm_pkg::LC_MASK) == ssmm_pkg::LC_BASE) begin
          if (!a[0]) sw_state.hram_write = 1'b0;
          sw_state.pre_write = 1'b0;
          select_bank(a);
        end else if ((a & ssmm_pkg::LC_MASK) == ssmm_pkg::SW_BASE) begin
          case (a[3:1])
            ssmm_pkg::SW_80STORE: sw_state.store80   = a[0];
            ssmm_pkg::SW_AUXRD:   sw_state.aux_read  = a[0];
            ssmm_pkg::SW_AUXWR:   sw_state.aux_write = a[0];
            ssmm_pkg::SW_CXROM:   sw_state.cx_rom    = a[0];
            ssmm_pkg::SW_ALTZP:   sw_state.alt_zp    = a[0];
            ssmm_pkg::SW_SLOTC3:  sw_state.slot_c3   = a[0];
            default: ;
          endcase
        end else if (a[15:8] == ssmm_pkg::C3_PAGE) begin
          if (!sw_state.slot_c3) sw_state.c8_rom = 1'b1;
        end else if (a == ssmm_pkg::C8_OFF_ADDR) begin
          sw_state.c8_rom = 1'b0;
        end
      end
      ssmm_pkg::MODE_RESET: begin
        // hires and page2 survive a bus reset
        keep_hires = sw_state.hires;
        keep_page2 = sw_state.page2;
        sw_state = '0;
        sw_state.hires = keep_hires;
        sw_state.page2 = keep_page2;
      end
      ssmm_pkg::MODE_HIRES: sw_state.hires = it.flag_value;
      ssmm_pkg::MODE_PAGE2: sw_state.page2 = it.flag_value;
      default: ;
    endcase
    c3 = sw_state.cx_rom | !sw_state.slot_c3;
    c8 = sw_state.cx_rom | sw_state.c8_rom;
    r.hram_read_on   = sw_state.hram_read;
    r.hram_write_on  = sw_state.hram_write;
    r.bank_one       = sw_state.bank_one;
    r.aux_zero_page  = sw_state.alt_zp;
    r.aux_read_map   = aux_regions(sw_state.aux_read);
    r.aux_write_map  = aux_regions(sw_state.aux_write);
    r.cxxx_read_map  = {c8, sw_state.cx_rom, c3, sw_state.cx_rom};
    r.cxxx_write_map = {c8, 1'b0, c3, 1'b0};
    r.store80_on     = sw_state.store80;
    return r;
  endfunction

  // ---------------------------------------------------------------- result side

  task automatic check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
    if (act !== exp) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, exp, act);
    end
  endtask

  task automatic check_result();
    ssmm_pkg::result_t exp;
    if (expected_maps.size() == 0) begin
      mismatches++;
      $display("%0t: result beat with nothing expected, read_data actual %h", $time,
               out_if.read_data);
    end else begin
      exp = expected_maps.pop_front();
      check_field("read_data", exp.read_data, out_if.read_data);
      check_field("hram_read_on", 8'(exp.hram_read_on), 8'(out_if.hram_read_on));
      check_field("hram_write_on", 8'(exp.hram_write_on), 8'(out_if.hram_write_on));
      check_field("bank_one", 8'(exp.bank_one), 8'(out_if.bank_one));
      check_field("aux_zero_page", 8'(exp.aux_zero_page), 8'(out_if.aux_zero_page));
      check_field("aux_read_map", 8'(exp.aux_read_map), 8'(out_if.aux_read_map));
      check_field("aux_write_map", 8'(exp.aux_write_map), 8'(out_if.aux_write_map));
      check_field("cxxx_read_map", 8'(exp.cxxx_read_map), 8'(out_if.cxxx_read_map));
      check_field("cxxx_write_map", 8'(exp.cxxx_write_map), 8'(out_if.cxxx_write_map));
      check_field("store80_on", 8'(exp.store80_on), 8'(out_if.store80_on));
      check_field("slot_cfff_read", 8'(exp.slot_cfff_read), 8'(out_if.slot_cfff_read));
    end
  endtask

  always @(posedge clk) begin : result_monitor
    if (out_if.valid && out_if.ready) check_result();
    // hold ready low through a long stall so the block backs up into its input
    if (hold_off_seen != hold_off_req) begin
      hold_off_seen <= hold_off_req;
      stall_left    <= HOLD_OFF_CYCLES;
      out_if.ready  <= 1'b0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- access side

  task automatic drive_item(input ssmm_pkg::item_t it);
    in_if.mode          <= it.mode;
    in_if.address       <= it.address;
    in_if.flag_value    <= it.flag_value;
    in_if.keyboard_data <= it.keyboard_data;
    in_if.rom_data      <= it.rom_data;
    in_if.floating_data <= it.floating_data;
    in_if.video_text    <= it.video_text;
    in_if.video_mixed   <= it.video_mixed;
    in_if.video_altchar <= it.video_altchar;
    in_if.video_col80   <= it.video_col80;
    in_if.video_vbl     <= it.video_vbl;
  endtask

  // Call right after a rising edge; returns at the edge that accepted the beat.
  task automatic offer_access(input ssmm_pkg::item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    drive_item(it);
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    expected_maps.push_back(predict_access(it));
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (expected_maps.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] lc_addr(input logic [3:0] sel);
    return {ssmm_pkg::LC_BASE[15:4], sel};
  endfunction

  function automatic logic [15:0] sw_addr(input logic [2:0] sel, input logic on);
    return {ssmm_pkg::SW_BASE[15:4], sel, on};
  endfunction

  function automatic logic [15:0] stat_addr(input logic [3:0] sel);
    return {ssmm_pkg::STAT_PAGE, sel};
  endfunction

  function automatic ssmm_pkg::item_t make_access(input logic [2:0] mode, input logic [15:0] a,
                                                  input logic fv);
    ssmm_pkg::item_t it;
    it.mode          = mode;
    it.address       = a;
    it.flag_value    = fv;
    it.keyboard_data = 8'($urandom_range(255));
    it.rom_data      = 8'($urandom_range(255));
    it.floating_data = 8'($urandom_range(255));
    it.video_text    = 1'($urandom_range(1));
    it.video_mixed   = 1'($urandom_range(1));
    it.video_altchar = 1'($urandom_range(1));
    it.video_col80   = 1'($urandom_range(1));
    it.video_vbl     = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic ssmm_pkg::item_t random_access();
    int unsigned   pick;
    logic [2:0]    mode;
    logic [15:0]   a;
    logic [15:0]   raw;
    pick = $urandom_range(99);
    if (pick < 40)      mode = ssmm_pkg::MODE_READ;
    else if (pick < 75) mode = ssmm_pkg::MODE_WRITE;
    else if (pick < 80) mode = ssmm_pkg::MODE_RESET;
    else if (pick < 87) mode = ssmm_pkg::MODE_HIRES;
    else if (pick < 94) mode = ssmm_pkg::MODE_PAGE2;
    else                mode = 3'($urandom_range(MODE_LAST, ssmm_pkg::MODE_PAGE2 + 3'd1));
    raw  = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    // bias toward the decoded pages, keep some fully random addresses
    if (pick < 20)      a = lc_addr(raw[3:0]);
    else if (pick < 35) a = {ssmm_pkg::SW_BASE[15:4], raw[3:0]};
    else if (pick < 50) a = stat_addr(raw[3:0]);
    else if (pick < 62) a = {ssmm_pkg::C3_PAGE, raw[7:0]};
    else if (pick < 70) a = ssmm_pkg::C8_OFF_ADDR;
    else if (pick < 80) a = {ssmm_pkg::CX_NIBBLE, raw[11:0]};
    else                a = raw;
    return make_access(mode, a, 1'($urandom_range(1)));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    ssmm_pkg::item_t it;
    it = make_access(ssmm_pkg::MODE_READ, 16'h0000, 1'b1);
    it.keyboard_data = '1; it.rom_data = '1; it.floating_data = '1;
    it.video_text = 1'b1; it.video_mixed = 1'b1; it.video_altchar = 1'b1;
    it.video_col80 = 1'b1; it.video_vbl = 1'b1;
    offer_access(it);
    it = make_access(ssmm_pkg::MODE_WRITE, 16'hFFFF, 1'b0);
    it.keyboard_data = '0; it.rom_data = '0; it.floating_data = '0;
    it.video_text = 1'b0; it.video_mixed = 1'b0; it.video_altchar = 1'b0;
    it.video_col80 = 1'b0; it.video_vbl = 1'b0;
    offer_access(it);
    it = make_access(ssmm_pkg::MODE_READ, stat_addr(ssmm_pkg::ST_BANK2), 1'b0);
    it.keyboard_data = '1;
    offer_access(it);
    // 80STORE with hires and page2 pulls the display regions over to aux
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(ssmm_pkg::SW_80STORE, 1'b1), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_HIRES, 16'h0000, 1'b1));
    offer_access(make_access(ssmm_pkg::MODE_PAGE2, 16'h0000, 1'b1));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(ssmm_pkg::SW_AUXRD, 1'b1), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(ssmm_pkg::SW_AUXWR, 1'b1), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(ssmm_pkg::SW_ALTZP, 1'b1), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(ssmm_pkg::SW_SLOTC3, 1'b1), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_READ, {ssmm_pkg::C3_PAGE, 8'hFF}, 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(ssmm_pkg::SW_SLOTC3, 1'b0), 1'b0));
    // arm the C800 ROM through C3xx, then drop it with a CFFF read
    offer_access(make_access(ssmm_pkg::MODE_READ, {ssmm_pkg::C3_PAGE, 8'h00}, 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_READ, ssmm_pkg::C8_OFF_ADDR, 1'b0));
    // two odd reads enable high-RAM writes; a write clears pre-write, even clears enable
    offer_access(make_access(ssmm_pkg::MODE_READ, lc_addr(4'hB), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_READ, lc_addr(4'hB), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, lc_addr(4'h1), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, lc_addr(4'h0), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(ssmm_pkg::SW_CXROM, 1'b1), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_WRITE, sw_addr(SW_SPARE, 1'b1), 1'b0));
    it = make_access(ssmm_pkg::MODE_READ, stat_addr(ssmm_pkg::ST_VBL), 1'b0);
    it.video_vbl = 1'b1;
    offer_access(it);
    offer_access(make_access(ssmm_pkg::MODE_READ, stat_addr(ST_COL80), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_READ, stat_addr(ST_FLOAT), 1'b0));
    offer_access(make_access(ssmm_pkg::MODE_RESET, 16'h0000, 1'b0));
    offer_access(make_access(MODE_LAST, 16'hC081, 1'b1));
    offer_access(make_access(ssmm_pkg::MODE_READ, stat_addr(ssmm_pkg::ST_HIRES), 1'b0));
  endtask

  task automatic test_random(input int count);
    ssmm_pkg::item_t it;
    logic [3:0] nib;
    int         sent;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 15) begin
        // paired bank-switch reads: an odd one, then usually the same odd address again
        nib    = 4'($urandom_range(15));
        nib[0] = 1'b1;
        it = make_access(ssmm_pkg::MODE_READ, lc_addr(nib), 1'b0);
        offer_access(it);
        if ($urandom_range(3) == 0) nib = 4'($urandom_range(15));
        offer_access(make_access(ssmm_pkg::MODE_READ, lc_addr(nib), 1'b0));
        sent += 2;
      end else begin
        offer_access(random_access());
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off_req++;
    repeat (40) offer_access(random_access());
  endtask

  initial begin
    sw_state = '0;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    drive_item('0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    wait_drained();

    send_idle_pct = 25;
    recv_idle_pct = 70;
    test_random(250);
    send_idle_pct = 70;
    recv_idle_pct = 25;
    test_random(250);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    wait_drained();
    test_random(160);
    wait_drained();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_maps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
